>>> rtl/gtm_pkg.sv
// Shared constants, template ROM and helper functions for the glyph template matcher.
`default_nettype none

package gtm_pkg;

   localparam int unsigned ROM_SIZE           = 45;
   localparam int unsigned DEF_TEMPLATE_COUNT = 45;
   localparam int unsigned DEF_PATTERN_BITS   = 56;
   localparam int unsigned IDX_W              = 6;
   localparam int unsigned WORD_W             = 64;

   typedef struct packed {
      logic valid;
   } stage_ctl_type;

   localparam logic [WORD_W-1:0] TMPL_ROM [ROM_SIZE] = '{
      64'h001071B22C7FE0C1, 64'h00F90A17C87060FE, 64'h00FD02040810207F,
      64'h00FD060C183060FF, 64'h00FD0207C810207F, 64'h00FD0207C8102040,
      64'h00FD06040813A27C, 64'h0083060FF83060C1, 64'h003820408102041C,
      64'h00FE04081028617C, 64'h00830A268F112141, 64'h008102040810207F,
      64'h00838EAC983060C1, 64'h0083868C98B0E0C1, 64'h007D8E0C183071BE,
      64'h00FD0E0FF8102040, 64'h007D8E0C1838DF03, 64'h00FD0E0FF9112141,
      64'h007F0203E02040FE, 64'h00FE204081020408, 64'h0083060C183060BE,
      64'h0083060A244A9B14, 64'h0083060A24450A08, 64'h008288A081051141,
      64'h008288A081020408, 64'h00FE08208208207F, 64'h001061408102043E,
      64'h003888104104107E, 64'h00388811C040911C, 64'h0000106144913F04,
      64'h00FD03E42040911C, 64'h007D06058C90A13C, 64'h00FE041041041040,
      64'h00790A13C850A13C, 64'h007D0A33A040911C, 64'h00790A142850A13C,
      64'h0000000000000008, 64'h0010204081020008, 64'h0038881041040010,
      64'h0000000080000410, 64'h00144BF9429FD228, 64'h0000000080000400,
      64'h007D060DDAB7A03E, 64'h001020408102043E, 64'h0000000000000000
   };

   // Slots past the stored templates read as an all-zero pattern.
   function automatic logic [WORD_W-1:0] tmpl_word(input logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] w;
      w = '0;
      if (idx < IDX_W'(ROM_SIZE)) begin
         w = TMPL_ROM[idx];
      end
      return w;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   // One register stage after every second compare level, and after the last one.
   function automatic int unsigned tree_stages(input int unsigned levels);
      return (levels + 1) / 2;
   endfunction

endpackage

`default_nettype wire

>>> rtl/gtm_score.sv
// Two-stage XOR and bit-count scoring of one glyph against every template.
`default_nettype none

module gtm_score #(
   parameter int unsigned TEMPLATE_COUNT = gtm_pkg::DEF_TEMPLATE_COUNT,
   parameter int unsigned PATTERN_BITS   = gtm_pkg::DEF_PATTERN_BITS,
   parameter int unsigned SCORE_W        = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gtm_pkg::stage_ctl_type        in_ctl,
   input  wire logic [PATTERN_BITS-1:0]       in_glyph,
   output gtm_pkg::stage_ctl_type             out_ctl,
   output logic [TEMPLATE_COUNT*SCORE_W-1:0]  out_scores
);
   import gtm_pkg::*;

   localparam int unsigned CHUNKS  = (PATTERN_BITS + 7) / 8;
   localparam int unsigned CHUNK_W = CHUNKS * 8;

   logic [3:0]         cnt_in  [TEMPLATE_COUNT][CHUNKS];
   logic [3:0]         cnt_ff  [TEMPLATE_COUNT][CHUNKS];
   logic [SCORE_W-1:0] score_in [TEMPLATE_COUNT];
   logic [SCORE_W-1:0] score_ff [TEMPLATE_COUNT];
   logic               cnt_vld_ff;
   logic               score_vld_ff;

   for (genvar t = 0; t < TEMPLATE_COUNT; t++) begin : g_tmpl
      localparam logic [WORD_W-1:0] TW = tmpl_word(IDX_W'(t));
      logic [CHUNK_W-1:0] diff_bits;

      assign diff_bits = CHUNK_W'(in_glyph ^ TW[PATTERN_BITS-1:0]);

      for (genvar c = 0; c < CHUNKS; c++) begin : g_chunk
         assign cnt_in[t][c] = pop8(diff_bits[c*8 +: 8]);
      end

      // Differing and agreeing counts; the larger one is the score.
      always_comb begin
         logic [SCORE_W-1:0] diff;
         logic [SCORE_W-1:0] same;
         diff = '0;
         for (int c = 0; c < CHUNKS; c++) begin
            diff = diff + SCORE_W'(cnt_ff[t][c]);
         end
         same = SCORE_W'(PATTERN_BITS) - diff;
         score_in[t] = (diff > same) ? diff : same;
      end

      assign out_scores[t*SCORE_W +: SCORE_W] = score_ff[t];
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      score_ff <= score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff   <= 1'b0;
         score_vld_ff <= 1'b0;
      end else begin
         cnt_vld_ff   <= in_ctl.valid;
         score_vld_ff <= cnt_vld_ff;
      end
   end

   assign out_ctl.valid = score_vld_ff;

endmodule

`default_nettype wire

>>> rtl/gtm_argmax.sv
// Registered compare tree that picks the highest score, lower index on a tie.
`default_nettype none

module gtm_argmax #(
   parameter int unsigned TEMPLATE_COUNT = gtm_pkg::DEF_TEMPLATE_COUNT,
   parameter int unsigned SCORE_W        = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gtm_pkg::stage_ctl_type        in_ctl,
   input  wire logic [TEMPLATE_COUNT*SCORE_W-1:0] in_scores,
   output gtm_pkg::stage_ctl_type             out_ctl,
   output logic [SCORE_W-1:0]                 out_best_score,
   output logic [gtm_pkg::IDX_W-1:0]          out_best_idx
);
   import gtm_pkg::*;

   localparam int unsigned LEVELS = $clog2(TEMPLATE_COUNT);
   localparam int unsigned LEAVES = 1 << LEVELS;
   localparam int unsigned NODE_W = SCORE_W + IDX_W;

   // Each node holds the score above the template index.
   logic [NODE_W-1:0] node [LEVELS+1][LEAVES];
   logic              vld  [LEVELS+1];

   // Padding leaves carry a zero score, which no real template can tie.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < TEMPLATE_COUNT) begin : g_real
         assign node[0][i] = {in_scores[i*SCORE_W +: SCORE_W], IDX_W'(i)};
      end else begin : g_pad
         assign node[0][i] = '0;
      end
   end
   assign vld[0] = in_ctl.valid;

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      localparam int unsigned WIDTH = LEAVES >> (l + 1);
      localparam bit          REG   = (l % 2 == 1) || (l == LEVELS - 1);

      for (genvar j = 0; j < LEAVES; j++) begin : g_node
         if (j < WIDTH) begin : g_used
            logic [NODE_W-1:0] win;
            logic [NODE_W-1:0] lo;
            logic [NODE_W-1:0] hi;
            assign lo  = node[l][2*j];
            assign hi  = node[l][2*j+1];
            assign win = (hi[NODE_W-1:IDX_W] > lo[NODE_W-1:IDX_W]) ? hi : lo;
            if (REG) begin : g_reg
               always_ff @(posedge clock) begin
                  node[l+1][j] <= win;
               end
            end else begin : g_wire
               assign node[l+1][j] = win;
            end
         end else begin : g_idle
            assign node[l+1][j] = '0;
         end
      end

      if (REG) begin : g_vreg
         always_ff @(posedge clock) begin
            if (reset) begin
               vld[l+1] <= 1'b0;
            end else begin
               vld[l+1] <= vld[l];
            end
         end
      end else begin : g_vwire
         assign vld[l+1] = vld[l];
      end
   end

   assign out_ctl.valid  = vld[LEVELS];
   assign out_best_score = node[LEVELS][0][NODE_W-1:IDX_W];
   assign out_best_idx   = node[LEVELS][0][IDX_W-1:0];

endmodule

`default_nettype wire

>>> rtl/glyph_template_matcher.sv
// Top level: nearest-template matcher for 8x7 binary glyphs.
// An item passes the input, scoring, tree and output registers on its way to rsp_strobe.
// One item is taken every cycle; busy stays low because every stage advances each cycle.
// Results are strobed for one cycle and the receiver cannot stall them.
// Synchronous reset clears all valid bits; payload registers are not reset.
`default_nettype none

module glyph_template_matcher #(
   parameter int unsigned TEMPLATE_COUNT = gtm_pkg::DEF_TEMPLATE_COUNT,
   parameter int unsigned PATTERN_BITS   = gtm_pkg::DEF_PATTERN_BITS,
   localparam int unsigned SCORE_W       = $clog2(PATTERN_BITS + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [PATTERN_BITS-1:0]     req_glyph_bits,
   output logic                             rsp_strobe,
   output logic [gtm_pkg::IDX_W-1:0]        rsp_match_index,
   output logic [PATTERN_BITS-1:0]          rsp_match_pattern,
   output logic [SCORE_W-1:0]               rsp_match_score
);
   import gtm_pkg::*;

   localparam int unsigned LATENCY = 4 + tree_stages($clog2(TEMPLATE_COUNT));

   logic                              in_vld_ff;
   logic [PATTERN_BITS-1:0]           glyph_ff;
   stage_ctl_type                     in_ctl;
   stage_ctl_type                     score_ctl;
   stage_ctl_type                     best_ctl;
   logic [TEMPLATE_COUNT*SCORE_W-1:0] scores;
   logic [SCORE_W-1:0]                best_score;
   logic [IDX_W-1:0]                  best_idx;
   logic [WORD_W-1:0]                 best_word;
   logic [PATTERN_BITS-1:0]           pat_in;
   logic                              out_vld_ff;
   logic [IDX_W-1:0]                  idx_ff;
   logic [PATTERN_BITS-1:0]           pat_ff;
   logic [SCORE_W-1:0]                score_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= req_glyph_bits;
   end

   assign in_ctl.valid = in_vld_ff;

   gtm_score #(
      .TEMPLATE_COUNT (TEMPLATE_COUNT),
      .PATTERN_BITS   (PATTERN_BITS),
      .SCORE_W        (SCORE_W)
   ) u_score (
      .clock      (clock),
      .reset      (reset),
      .in_ctl     (in_ctl),
      .in_glyph   (glyph_ff),
      .out_ctl    (score_ctl),
      .out_scores (scores)
   );

   gtm_argmax #(
      .TEMPLATE_COUNT (TEMPLATE_COUNT),
      .SCORE_W        (SCORE_W)
   ) u_argmax (
      .clock          (clock),
      .reset          (reset),
      .in_ctl         (score_ctl),
      .in_scores      (scores),
      .out_ctl        (best_ctl),
      .out_best_score (best_score),
      .out_best_idx   (best_idx)
   );

   // The winning bitmap is looked up again from the ROM by its index.
   assign best_word = tmpl_word(best_idx);
   assign pat_in    = best_word[PATTERN_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= best_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= best_idx;
      pat_ff   <= pat_in;
      score_ff <= best_score;
   end

   assign rsp_strobe        = out_vld_ff;
   assign rsp_match_index   = idx_ff;
   assign rsp_match_pattern = pat_ff;
   assign rsp_match_score   = score_ff;

   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result at the expected cycle");

   a_no_spurious_result : assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LATENCY !rsp_strobe)
      else $error("result strobed without a matching accepted item");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_match_index} < (IDX_W + 1)'(TEMPLATE_COUNT)))
      else $error("winning index beyond the template count");

   a_score_at_least_half : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_match_score, 1'b0} >= (SCORE_W + 2)'(PATTERN_BITS)))
      else $error("winning score below half the pattern width");

endmodule

`default_nettype wire
